// ===== hdl/isc_pkg.sv =====
package isc_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int SLOT_BITS   = 6;
	localparam int MAX_RESULTS = 8;
	localparam logic [9:0] MS_PER_S = 10'd1000;

	localparam logic [1:0] REQ_DATA   = 2'd0;
	localparam logic [1:0] REQ_TICK   = 2'd1;
	localparam logic [1:0] REQ_ADD    = 2'd2;
	localparam logic [1:0] REQ_REMOVE = 2'd3;

	localparam logic [2:0] STAT_DONE     = 3'd0;
	localparam logic [2:0] STAT_REPORT   = 3'd1;
	localparam logic [2:0] STAT_NOTFOUND = 3'd2;
	localparam logic [2:0] STAT_FULL     = 3'd3;
	localparam logic [2:0] STAT_ZERO_IVL = 3'd4;

	localparam logic [2:0] KIND_PER_SEC = 3'd0;
	localparam logic [2:0] KIND_ISUM    = 3'd1;
	localparam logic [2:0] KIND_TSUM    = 3'd2;
	localparam logic [2:0] KIND_SNAP    = 3'd3;
	localparam logic [2:0] KIND_MEAN    = 3'd4;

	// command codes between front and back
	localparam logic [1:0] CMD_DATA = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_ADD  = 2'd2;
	localparam logic [1:0] CMD_RESP = 2'd3;

	typedef struct packed {
		logic [1:0]             op;
		logic [SLOT_BITS-1:0]   slot;
		logic [2:0]             status;
		logic [31:0]            sample;
		logic [63:0]            now;
		logic [2:0]             kind;
		logic [15:0]            ival;
		logic [31:0]            mul;
		logic [31:0]            dv;
		logic [MAX_ENTRIES-1:0] mask;
	} isc_cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  entry;
		logic [63:0] value;
		logic        last;
	} isc_res_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] ival;
		logic [31:0] mul;
		logic [31:0] dv;
		logic [63:0] last_rep;
		logic [63:0] isum;
		logic [63:0] tsum;
		logic [31:0] cnt;
	} isc_rec_t;

endpackage

// ===== hdl/isc_fifo.sv =====
module isc_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  T     wdata,
	output logic full,
	input  logic rd,
	output T     rdata,
	output logic empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T               buf_q [DEPTH];
	logic [AW-1:0]  wp_q, rp_q;
	logic [CW-1:0]  cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			buf_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !full) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd && !empty) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			case ({wr && !full, rd && !empty})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// ===== hdl/isc_div.sv =====
module isc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);
	import isc_pkg::*;

	logic [63:0] rem_q, quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        run_q, done_q;
	logic [64:0] r2;
	logic        ge;

	// restoring divide, one quotient bit per cycle
	always_comb begin
		r2 = {rem_q, quo_q[63]};
		ge = (r2 >= {1'b0, dvs_q});
	end

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? 64'(r2 - {1'b0, dvs_q}) : r2[63:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

// ===== hdl/isc_front.sv =====
module isc_front #(
	parameter int ENTRIES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [1:0]       req_type,
	input  logic [2:0]       entry_id,
	input  logic [31:0]      sample_value,
	input  logic [63:0]      now_ms,
	input  logic [2:0]       stat_kind,
	input  logic [15:0]      interval_s,
	input  logic [31:0]      mul_coef,
	input  logic [31:0]      div_coef,
	output isc_pkg::isc_cmd_t cmd
);
	import isc_pkg::*;

	localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [ENTRIES-1:0] valid_q;
	logic [SW-1:0]      id_idx, free_idx;
	logic               id_ok, found, free_found;

	always_comb begin
		id_idx = SW'(entry_id);
		id_ok  = ({29'b0, entry_id} < 32'(ENTRIES));
		found  = id_ok && valid_q[id_idx];
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = SW'(i);
			end
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.sample = sample_value;
		cmd.now    = now_ms;
		cmd.kind   = stat_kind;
		cmd.ival   = interval_s;
		cmd.mul    = mul_coef;
		cmd.dv     = div_coef;
		cmd.mask   = MAX_ENTRIES'(valid_q);
		cmd.slot   = SLOT_BITS'(entry_id);
		case (req_type)
			REQ_DATA: begin
				cmd.op     = found ? CMD_DATA : CMD_RESP;
				cmd.status = STAT_NOTFOUND;
			end
			REQ_TICK: begin
				cmd.op = CMD_TICK;
			end
			REQ_ADD: begin
				if (interval_s == '0) begin
					cmd.op     = CMD_RESP;
					cmd.status = STAT_ZERO_IVL;
					cmd.slot   = '0;
				end else if (!free_found) begin
					cmd.op     = CMD_RESP;
					cmd.status = STAT_FULL;
					cmd.slot   = '0;
				end else begin
					cmd.op   = CMD_ADD;
					cmd.slot = SLOT_BITS'(free_idx);
				end
			end
			default: begin
				cmd.op     = CMD_RESP;
				cmd.status = found ? STAT_DONE : STAT_NOTFOUND;
			end
		endcase
	end

	// slot occupancy is tracked here, in accept order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (accept) begin
			if (req_type == REQ_ADD && interval_s != '0 && free_found) begin
				valid_q[free_idx] <= 1'b1;
			end else if (req_type == REQ_REMOVE && found) begin
				valid_q[id_idx] <= 1'b0;
			end
		end
	end
endmodule

// ===== hdl/isc_back.sv =====
module isc_back #(
	parameter int ENTRIES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  isc_pkg::isc_cmd_t cmd,
	input  logic              cmd_empty,
	output logic              cmd_pop,
	output isc_pkg::isc_res_t res,
	output logic              res_push,
	input  logic              res_full
);
	import isc_pkg::*;

	localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DRD  = 4'd1;
	localparam logic [3:0] ST_SCAN = 4'd2;
	localparam logic [3:0] ST_CHK  = 4'd3;
	localparam logic [3:0] ST_DW1  = 4'd4;
	localparam logic [3:0] ST_MUL  = 4'd5;
	localparam logic [3:0] ST_MULH = 4'd6;
	localparam logic [3:0] ST_DIV2 = 4'd7;
	localparam logic [3:0] ST_DW2  = 4'd8;
	localparam logic [3:0] ST_EMIT = 4'd9;
	localparam logic [3:0] ST_FIN  = 4'd10;

	isc_rec_t mem_q [ENTRIES];
	isc_rec_t rd_q, mem_wd, upd;
	logic          mem_we;
	logic [SW-1:0] mem_wa, mem_ra;

	logic [3:0]         state_q;
	logic [SW:0]        idx_q;
	logic [3:0]         n_q;
	logic [ENTRIES-1:0] mask_q;
	logic [63:0]        now_q, v_q, plo_q, pend_val_q, mh;
	logic [31:0]        smp_q, mul_q, dv_q;
	logic [SW-1:0]      slot_q, pend_slot_q, idx;
	logic               pend_q;

	logic        div_start, div_done;
	logic [63:0] div_a, div_b, div_q;
	logic [25:0] ival_ms;
	logic        hit;

	isc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rd_q <= mem_q[mem_ra];
	end

	always_comb begin
		idx     = idx_q[SW-1:0];
		ival_ms = 26'(rd_q.ival) * 26'(MS_PER_S);
		hit     = ((rd_q.last_rep + 64'(ival_ms)) <= now_q) && (rd_q.kind <= KIND_MEAN);
		mh      = 64'(v_q[63:32]) * 64'(mul_q);
		upd     = rd_q;
		if (rd_q.kind == KIND_SNAP) begin
			upd.isum = 64'(smp_q);
		end else begin
			upd.isum = rd_q.isum + 64'(smp_q);
			upd.tsum = rd_q.tsum + 64'(smp_q);
		end
		upd.cnt = rd_q.cnt + 32'd1;
	end

	always_comb begin
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		res       = '0;
		mem_we    = 1'b0;
		mem_wa    = slot_q;
		mem_wd    = rd_q;
		mem_ra    = slot_q;
		div_start = 1'b0;
		div_a     = v_q;
		div_b     = 64'(dv_q);
		case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					case (cmd.op)
						CMD_RESP: begin
							if (!res_full) begin
								cmd_pop  = 1'b1;
								res_push = 1'b1;
								res      = '{cmd.status, cmd.slot[2:0], 64'd0, 1'b1};
							end
						end
						CMD_ADD: begin
							if (!res_full) begin
								cmd_pop  = 1'b1;
								res_push = 1'b1;
								res      = '{STAT_DONE, cmd.slot[2:0], 64'd0, 1'b1};
								mem_we   = 1'b1;
								mem_wa   = cmd.slot[SW-1:0];
								mem_wd   = '{cmd.kind, cmd.ival, cmd.mul, cmd.dv, cmd.now,
									64'd0, 64'd0, 32'd0};
							end
						end
						CMD_DATA: begin
							cmd_pop = 1'b1;
							mem_ra  = cmd.slot[SW-1:0];
						end
						default: begin
							cmd_pop = 1'b1;
						end
					endcase
				end
			end
			ST_DRD: begin
				if (!res_full) begin
					res_push = 1'b1;
					res      = '{STAT_DONE, 3'(slot_q), 64'd0, 1'b1};
					mem_we   = 1'b1;
					mem_wd   = upd;
				end
			end
			ST_SCAN: begin
				mem_ra = idx;
			end
			ST_CHK: begin
				if (hit) begin
					mem_we          = 1'b1;
					mem_wa          = idx;
					mem_wd          = rd_q;
					mem_wd.last_rep = now_q;
					mem_wd.isum     = '0;
					mem_wd.cnt      = '0;
					if (rd_q.kind == KIND_PER_SEC) begin
						div_start = 1'b1;
						div_a     = rd_q.isum * 64'(MS_PER_S);
						div_b     = 64'(rd_q.ival);
					end else if (rd_q.kind == KIND_MEAN && rd_q.cnt != '0) begin
						div_start = 1'b1;
						div_a     = rd_q.isum;
						div_b     = 64'(rd_q.cnt);
					end
				end
			end
			ST_DIV2: begin
				div_start = (dv_q != '0);
			end
			ST_EMIT: begin
				if (pend_q && !res_full) begin
					res_push = 1'b1;
					res      = '{STAT_REPORT, 3'(pend_slot_q), pend_val_q, 1'b0};
				end
			end
			ST_FIN: begin
				if (!res_full) begin
					res_push = 1'b1;
					if (pend_q) begin
						res = '{STAT_REPORT, 3'(pend_slot_q), pend_val_q, 1'b1};
					end else begin
						res = '{STAT_DONE, 3'd0, 64'd0, 1'b1};
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				slot_q <= cmd.slot[SW-1:0];
				smp_q  <= cmd.sample;
				now_q  <= cmd.now;
				mask_q <= cmd.mask[ENTRIES-1:0];
			end
			ST_CHK: begin
				mul_q <= rd_q.mul;
				dv_q  <= rd_q.dv;
				case (rd_q.kind)
					KIND_TSUM: v_q <= rd_q.tsum;
					KIND_MEAN: v_q <= '0;
					default:   v_q <= rd_q.isum;
				endcase
			end
			ST_DW1, ST_DW2: begin
				if (div_done) begin
					v_q <= div_q;
				end
			end
			ST_MUL: begin
				plo_q <= 64'(v_q[31:0]) * 64'(mul_q);
			end
			ST_MULH: begin
				v_q <= plo_q + {mh[31:0], 32'd0};
			end
			ST_EMIT: begin
				// hold the older report until it has gone out
				if (!pend_q || !res_full) begin
					pend_slot_q <= idx;
					pend_val_q  <= v_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			n_q     <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						if (cmd.op == CMD_DATA) begin
							state_q <= ST_DRD;
						end else if (cmd.op == CMD_TICK) begin
							state_q <= ST_SCAN;
							idx_q   <= '0;
							n_q     <= '0;
							pend_q  <= 1'b0;
						end
					end
				end
				ST_DRD: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (idx_q == (SW + 1)'(ENTRIES) || n_q == 4'(MAX_RESULTS)) begin
						state_q <= ST_FIN;
					end else if (mask_q[idx]) begin
						state_q <= ST_CHK;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_CHK: begin
					if (!hit) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SCAN;
					end else if (div_start) begin
						state_q <= ST_DW1;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_DW1: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= (mul_q == '0) ? ST_DIV2 : ST_MULH;
				end
				ST_MULH: begin
					state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					state_q <= (dv_q != '0) ? ST_DW2 : ST_EMIT;
				end
				ST_DW2: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// previous report goes out only once a later one is known
					if (!pend_q || !res_full) begin
						pend_q  <= 1'b1;
						n_q     <= n_q + 1'b1;
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_FIN: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== hdl/interval_stats_counter_table.sv =====
// Table of periodic statistics counters.
// Input channel: push/full, one beat per request (data sample, tick, add,
// remove). Result channel: empty/pop, the oldest result is on the result
// ports while empty is low. A tick gives one result per due slot, in slot
// order, up to eight, with last_of_run on the final one; a tick with nothing
// due gives a single done result. Every other request gives one result.
// A front stage classifies requests and owns slot occupancy; a two-deep
// command queue feeds the back end, which owns the slot memory.
// Add, remove and errors are answered from the back end's idle state; data
// samples read the slot memory, then write it back. A tick reads and checks
// each occupied slot; a report may add a bit-serial 64-bit divide (per-second
// or mean kind), a multiply, and a second divide for a nonzero divisor.
// When the result queue is full the back end stalls; the front keeps taking
// requests until the command queue fills. Reset empties both queues and
// frees all slots.
module interval_stats_counter_table #(
	parameter int ENTRIES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [2:0]  entry_id,
	input  logic [31:0] sample_value,
	input  logic [63:0] now_ms,
	input  logic [2:0]  stat_kind,
	input  logic [15:0] interval_s,
	input  logic [31:0] mul_coef,
	input  logic [31:0] div_coef,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [2:0]  out_entry,
	output logic [63:0] report_value,
	output logic        last_of_run
);
	import isc_pkg::*;

	isc_cmd_t cmd_in, cmd_out;
	isc_res_t res_in, res_out;
	logic     accept, cmd_empty, cmd_pop, res_push, res_full;

	assign accept = push && !full;

	isc_front #(.ENTRIES(ENTRIES)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.req_type     (req_type),
		.entry_id     (entry_id),
		.sample_value (sample_value),
		.now_ms       (now_ms),
		.stat_kind    (stat_kind),
		.interval_s   (interval_s),
		.mul_coef     (mul_coef),
		.div_coef     (div_coef),
		.cmd          (cmd_in)
	);

	isc_fifo #(.T(isc_cmd_t), .DEPTH(2)) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept),
		.wdata  (cmd_in),
		.full   (full),
		.rd     (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	isc_back #(.ENTRIES(ENTRIES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res       (res_in),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	isc_fifo #(.T(isc_res_t), .DEPTH(2)) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.rd     (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign status       = res_out.status;
	assign out_entry    = res_out.entry;
	assign report_value = res_out.value;
	assign last_of_run  = res_out.last;

	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result written into a full queue");

	a_cmd_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command popped from an empty queue");

	a_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && !res_in.last) |-> (res_in.status == STAT_REPORT))
		else $error("non-final beat that is not a report");
endmodule
